### sv/lppd_pkg.sv
`default_nettype none

package lppd_pkg;

   localparam int DIST_WIDTH = 24;

   // travels with every item down the pipeline
   typedef struct packed {
      logic valid;
      logic parallel;
   } lppd_ctl_type;

endpackage

`default_nettype wire

### sv/lppd_isqrt.sv
`default_nettype none

module lppd_isqrt import lppd_pkg::*; #(
   parameter int RADW  = 106,
   parameter int SIDEW = 34
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire lppd_ctl_type          in_ctl,
   input  wire logic [RADW-1:0]       in_rad,
   input  wire logic [SIDEW-1:0]      in_side,
   output lppd_ctl_type               out_ctl,
   output logic      [RADW/2-1:0]     out_root,
   output logic      [SIDEW-1:0]      out_side
);

   localparam int RW = RADW / 2;

   lppd_ctl_type     ctl_ff  [RW];
   logic [RADW-1:0]  x_ff    [RW];
   logic [RW+1:0]    rem_ff  [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [SIDEW-1:0] side_ff [RW];

   // one result bit per stage, restoring digit-by-digit square root
   for (genvar i = 0; i < RW; i++) begin : g_stage
      lppd_ctl_type     ctl_prev;
      logic [RADW-1:0]  x_prev;
      logic [RW+1:0]    rem_prev;
      logic [RW-1:0]    root_prev;
      logic [SIDEW-1:0] side_prev;
      logic [RW+1:0]    rem_sh;
      logic [RW+1:0]    trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign x_prev    = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign ctl_prev  = ctl_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign rem_sh = {rem_prev[RW-1:0], x_prev[RADW-1 -: 2]};
      assign trial  = {root_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_prev << 2;
            rem_ff[i]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[i] <= {root_prev[RW-2:0], ge};
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

`default_nettype wire

### sv/lppd_div.sv
`default_nettype none

module lppd_div import lppd_pkg::*; #(
   parameter int NUMW = 53,
   parameter int DENW = 34
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire lppd_ctl_type          in_ctl,
   input  wire logic [NUMW-1:0]       in_num,
   input  wire logic [DENW-1:0]       in_den,
   output lppd_ctl_type               out_ctl,
   output logic      [DIST_WIDTH-1:0] out_quot,
   output logic                       out_sat
);

   localparam int TW = (NUMW > DENW + DIST_WIDTH) ? NUMW : DENW + DIST_WIDTH;
   localparam int NS = DIST_WIDTH + 1;

   lppd_ctl_type          ctl_ff [NS];
   logic [TW-1:0]         rem_ff [NS];
   logic [DENW-1:0]       den_ff [NS];
   logic [DIST_WIDTH-1:0] quo_ff [NS];
   logic                  sat_ff [NS];

   // first stage: quotient too large for the output
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= TW'(in_num);
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         sat_ff[0] <= (TW'(in_num) >= (TW'(in_den) << DIST_WIDTH));
      end
   end

   // one quotient bit per stage, msb first
   for (genvar j = 1; j < NS; j++) begin : g_stage
      logic [TW-1:0] trial;
      logic          ge;

      assign trial = TW'(den_ff[j-1]) << (DIST_WIDTH - j);
      assign ge    = (rem_ff[j-1] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (en) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? (rem_ff[j-1] - trial) : rem_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= {quo_ff[j-1][DIST_WIDTH-2:0], ge};
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign out_ctl  = ctl_ff[NS-1];
   assign out_quot = quo_ff[NS-1];
   assign out_sat  = sat_ff[NS-1];

endmodule

`default_nettype wire

### sv/line_plane_point_distance.sv
// line/plane intersection distance, fully pipelined
//
// input channel (req_*): one query per transfer, a line (point, direction)
// and a plane (point, normal), each coordinate a signed COORD_WIDTH-bit
// fixed-point value. result channel (rsp_*): distance from the plane point
// to the intersection in the same fixed-point units, floored, saturating
// at 2^24-1 with rsp_saturated set; rsp_is_parallel set with distance 0
// when direction dot normal is zero.
// the pipeline has eight stages of dot products and squaring, one
// stage per root bit of the square root, and 25 stages of the quotient
// divider. throughput is one query per cycle while no stalled receiver
// holds the pipeline.
// the whole pipeline advances together: it moves whenever the output
// register is empty or its transfer completes, so a stalled receiver
// holds every stage in place and req_ready drops; nothing is lost.
// synchronous reset empties the pipeline; there is no other state.
`default_nettype none

module line_plane_point_distance import lppd_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_line_pt_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_line_pt_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_line_pt_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_plane_pt_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_plane_pt_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_plane_pt_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_normal_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_normal_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_normal_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [DIST_WIDTH-1:0]  rsp_distance,
   output logic                               rsp_is_parallel,
   output logic                               rsp_saturated
);

   localparam int CW  = COORD_WIDTH;
   localparam int VW  = CW + 1;
   localparam int PW  = 2 * CW + 2;
   localparam int QW  = 2 * CW + 3;
   localparam int UW  = 3 * CW + 4;
   localparam int LW  = (UW + 1) / 2;
   localparam int HW  = UW - LW;
   localparam int SQW = 2 * UW;
   localparam int SW  = 2 * UW + 2;
   localparam int RW  = SW / 2;

   logic en;

   logic signed [CW-1:0] v_in [3];
   logic signed [CW-1:0] n_in [3];
   logic signed [VW-1:0] w_in [3];

   logic                 vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff, vld7_ff, vld8_ff;
   logic signed [CW-1:0] v1_ff [3];
   logic signed [CW-1:0] n1_ff [3];
   logic signed [VW-1:0] w1_ff [3];

   logic signed [2*CW-1:0] vn2_ff [3];
   logic signed [2*CW:0]   wn2_ff [3];
   logic signed [CW-1:0]   v2_ff  [3];
   logic signed [VW-1:0]   w2_ff  [3];

   logic signed [PW-1:0] p3_ff;
   logic signed [QW-1:0] q3_ff;
   logic signed [CW-1:0] v3_ff [3];
   logic signed [VW-1:0] w3_ff [3];

   logic signed [UW-1:0] wp4_ff [3];
   logic signed [UW-1:0] qv4_ff [3];
   logic signed [PW-1:0] p4_ff;

   logic signed [UW-1:0] u_diff [3];
   logic        [UW-1:0] um5_ff [3];
   logic        [PW-1:0] pm5_ff, pm6_ff, pm7_ff, pm8_ff;
   logic                 par5_ff, par6_ff, par7_ff, par8_ff;

   logic [2*HW-1:0]  hh6_ff [3];
   logic [HW+LW-1:0] hl6_ff [3];
   logic [2*LW-1:0]  ll6_ff [3];

   logic [SQW-1:0] sq7_ff [3];
   logic [SW-1:0]  uu8_ff;

   lppd_ctl_type         sq_ctl_in;
   lppd_ctl_type         sq_ctl_out;
   logic [RW-1:0]        root;
   logic [PW-1:0]        pm_sq;
   lppd_ctl_type         dv_ctl_out;
   logic [DIST_WIDTH-1:0] quot;
   logic                 sat;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign v_in[0] = req_dir_x;
   assign v_in[1] = req_dir_y;
   assign v_in[2] = req_dir_z;
   assign n_in[0] = req_normal_x;
   assign n_in[1] = req_normal_y;
   assign n_in[2] = req_normal_z;
   assign w_in[0] = VW'(req_line_pt_x) - VW'(req_plane_pt_x);
   assign w_in[1] = VW'(req_line_pt_y) - VW'(req_plane_pt_y);
   assign w_in[2] = VW'(req_line_pt_z) - VW'(req_plane_pt_z);

   for (genvar k = 0; k < 3; k++) begin : g_diff
      assign u_diff[k] = wp4_ff[k] - qv4_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            // input register
            v1_ff[k]  <= v_in[k];
            n1_ff[k]  <= n_in[k];
            w1_ff[k]  <= w_in[k];
            // dot product terms
            vn2_ff[k] <= v1_ff[k] * n1_ff[k];
            wn2_ff[k] <= w1_ff[k] * n1_ff[k];
            v2_ff[k]  <= v1_ff[k];
            w2_ff[k]  <= w1_ff[k];
            v3_ff[k]  <= v2_ff[k];
            w3_ff[k]  <= w2_ff[k];
            // u = w*P - Q*v, offset scaled by P
            wp4_ff[k] <= w3_ff[k] * p3_ff;
            qv4_ff[k] <= q3_ff * v3_ff[k];
            um5_ff[k] <= u_diff[k][UW-1] ? UW'(-u_diff[k]) : UW'(u_diff[k]);
            // square split into halves
            hh6_ff[k] <= um5_ff[k][UW-1:LW] * um5_ff[k][UW-1:LW];
            hl6_ff[k] <= um5_ff[k][UW-1:LW] * um5_ff[k][LW-1:0];
            ll6_ff[k] <= um5_ff[k][LW-1:0] * um5_ff[k][LW-1:0];
            sq7_ff[k] <= (SQW'(hh6_ff[k]) << (2 * LW))
                       + (SQW'(hl6_ff[k]) << (LW + 1))
                       + SQW'(ll6_ff[k]);
         end
         p3_ff   <= PW'(vn2_ff[0]) + PW'(vn2_ff[1]) + PW'(vn2_ff[2]);
         q3_ff   <= QW'(wn2_ff[0]) + QW'(wn2_ff[1]) + QW'(wn2_ff[2]);
         p4_ff   <= p3_ff;
         pm5_ff  <= p4_ff[PW-1] ? PW'(-p4_ff) : PW'(p4_ff);
         par5_ff <= (p4_ff == '0);
         pm6_ff  <= pm5_ff;
         par6_ff <= par5_ff;
         pm7_ff  <= pm6_ff;
         par7_ff <= par6_ff;
         pm8_ff  <= pm7_ff;
         par8_ff <= par7_ff;
         uu8_ff  <= SW'(sq7_ff[0]) + SW'(sq7_ff[1]) + SW'(sq7_ff[2]);
      end
   end

   assign sq_ctl_in.valid    = vld8_ff;
   assign sq_ctl_in.parallel = par8_ff;

   // floor(sqrt(uu)) / |P| gives floor(|u| / |P|)
   lppd_isqrt #(
      .RADW  (SW),
      .SIDEW (PW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (sq_ctl_in),
      .in_rad   (uu8_ff),
      .in_side  (pm8_ff),
      .out_ctl  (sq_ctl_out),
      .out_root (root),
      .out_side (pm_sq)
   );

   lppd_div #(
      .NUMW (RW),
      .DENW (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (sq_ctl_out),
      .in_num   (root),
      .in_den   (pm_sq),
      .out_ctl  (dv_ctl_out),
      .out_quot (quot),
      .out_sat  (sat)
   );

   assign rsp_valid       = dv_ctl_out.valid;
   assign rsp_is_parallel = dv_ctl_out.parallel;
   assign rsp_saturated   = !dv_ctl_out.parallel && sat;
   assign rsp_distance    = dv_ctl_out.parallel ? '0 : (sat ? '1 : quot);

endmodule

`default_nettype wire
